// File: hw/rtl/sfr_pkg.sv
// shared types and constants for the signed fraction reducer
// no dependencies

package sfr_pkg;

    localparam int MAG_W         = 64;  // width of the magnitude ports
    localparam int DEFAULT_WIDTH = 64;  // default datapath width

    typedef enum logic [2:0] {
        S_IDLE,
        S_EUC,
        S_EUC_WAIT,
        S_CHK,
        S_NUM_WAIT,
        S_DEN_WAIT
    } t_state;

endpackage

// File: hw/rtl/sfr_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on sfr_pkg for the default width

module sfr_div #(
    parameter int WIDTH = sfr_pkg::DEFAULT_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_active, n_active;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_den, n_den;

    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;
    logic             w_fit;

    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fit   = !w_diff[WIDTH];

    always_comb begin
        n_active = r_active;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_den    = r_den;
        if (i_go) begin
            n_active = 1'b1;
            n_cnt    = CNT_W'(WIDTH - 1);
            n_rem    = '0;
            n_quo    = i_dividend;
            n_den    = i_divisor;
        end else if (r_active) begin
            n_rem = w_fit ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
            n_quo = {r_quo[WIDTH-2:0], w_fit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_active = 1'b0;
                n_done   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_active <= n_active;
            r_done   <= n_done;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

`ifndef ASSERT_OFF
    // a new division never lands on one in flight
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> !r_active)
        else $error("divider started while active");

    // divisor is never zero
    a_go_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> (i_divisor != '0))
        else $error("divide by zero issued");

    // done follows the last step and the unit is then free
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!r_active && $past(r_active)))
        else $error("done without a finished division");
`endif

endmodule

// File: hw/rtl/signed_fraction_reducer.sv
// after the accepting edge the sequencer runs the euclid remainder steps (at most about 93 for
// 64 bits), then divides numerator and denominator by the gcd unless the gcd is 0 or 1
// no new word is taken until the last is done; one shared bit-serial divider does all steps
// busy is high from the accepting edge until the result strobe; results cannot be stalled
// reset (synchronous, active low) returns the sequencer to idle and clears the strobe
// depends on sfr_pkg and sfr_div

module signed_fraction_reducer #(
    parameter int WIDTH = sfr_pkg::DEFAULT_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [sfr_pkg::MAG_W-1:0] i_num_magnitude,
    input  logic                      i_num_negative,
    input  logic [sfr_pkg::MAG_W-1:0] i_den_magnitude,
    input  logic                      i_den_negative,
    output logic                      o_valid,
    output logic [sfr_pkg::MAG_W-1:0] o_reduced_num,
    output logic [sfr_pkg::MAG_W-1:0] o_reduced_den,
    output logic                      o_result_negative
);

    sfr_pkg::t_state r_state, n_state;

    logic             r_valid, n_valid;
    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [WIDTH-1:0] r_n, n_n;
    logic [WIDTH-1:0] r_d, n_d;
    logic             r_sign, n_sign;
    logic [sfr_pkg::MAG_W-1:0] r_out_num, n_out_num;
    logic [sfr_pkg::MAG_W-1:0] r_out_den, n_out_den;
    logic             r_out_sign, n_out_sign;

    logic             w_div_go;
    logic [WIDTH-1:0] w_div_a;
    logic [WIDTH-1:0] w_div_b;
    logic             w_div_done;
    logic [WIDTH-1:0] w_div_q;
    logic [WIDTH-1:0] w_div_r;

    sfr_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_div_go),
        .i_dividend  (w_div_a),
        .i_divisor   (w_div_b),
        .o_done      (w_div_done),
        .o_quotient  (w_div_q),
        .o_remainder (w_div_r)
    );

    always_comb begin
        n_state    = r_state;
        n_valid    = 1'b0;
        n_x        = r_x;
        n_y        = r_y;
        n_n        = r_n;
        n_d        = r_d;
        n_sign     = r_sign;
        n_out_num  = r_out_num;
        n_out_den  = r_out_den;
        n_out_sign = r_out_sign;
        w_div_go   = 1'b0;
        w_div_a    = r_x;
        w_div_b    = r_y;
        unique case (r_state)
            sfr_pkg::S_IDLE: begin
                if (start) begin
                    n_x     = i_num_magnitude[WIDTH-1:0];
                    n_y     = i_den_magnitude[WIDTH-1:0];
                    n_n     = i_num_magnitude[WIDTH-1:0];
                    n_d     = i_den_magnitude[WIDTH-1:0];
                    n_sign  = i_num_negative ^ i_den_negative;
                    n_state = sfr_pkg::S_EUC;
                end
            end
            sfr_pkg::S_EUC: begin
                if (r_y == '0) begin
                    n_state = sfr_pkg::S_CHK;
                end else begin
                    w_div_go = 1'b1;
                    n_state  = sfr_pkg::S_EUC_WAIT;
                end
            end
            sfr_pkg::S_EUC_WAIT: begin
                if (w_div_done) begin
                    n_x     = r_y;
                    n_y     = w_div_r;
                    n_state = sfr_pkg::S_EUC;
                end
            end
            sfr_pkg::S_CHK: begin
                // r_x now holds the gcd
                if (r_x > WIDTH'(1)) begin
                    w_div_go = 1'b1;
                    w_div_a  = r_n;
                    w_div_b  = r_x;
                    n_state  = sfr_pkg::S_NUM_WAIT;
                end else begin
                    n_valid    = 1'b1;
                    n_out_num  = sfr_pkg::MAG_W'(r_n);
                    n_out_den  = sfr_pkg::MAG_W'(r_d);
                    n_out_sign = r_sign;
                    n_state    = sfr_pkg::S_IDLE;
                end
            end
            sfr_pkg::S_NUM_WAIT: begin
                w_div_a = r_d;
                w_div_b = r_x;
                if (w_div_done) begin
                    n_n      = w_div_q;
                    w_div_go = 1'b1;
                    n_state  = sfr_pkg::S_DEN_WAIT;
                end
            end
            sfr_pkg::S_DEN_WAIT: begin
                if (w_div_done) begin
                    n_valid    = 1'b1;
                    n_out_num  = sfr_pkg::MAG_W'(r_n);
                    n_out_den  = sfr_pkg::MAG_W'(w_div_q);
                    n_out_sign = r_sign;
                    n_state    = sfr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sfr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfr_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_n        <= n_n;
        r_d        <= n_d;
        r_sign     <= n_sign;
        r_out_num  <= n_out_num;
        r_out_den  <= n_out_den;
        r_out_sign <= n_out_sign;
    end

    assign busy              = (r_state != sfr_pkg::S_IDLE);
    assign o_valid           = r_valid;
    assign o_reduced_num     = r_out_num;
    assign o_reduced_den     = r_out_den;
    assign o_result_negative = r_out_sign;

`ifndef ASSERT_OFF
    // an accepted word always makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    // the result strobe comes only as the sequencer returns to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a word");

    // the divider reports only while a wait state expects it
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == sfr_pkg::S_EUC_WAIT ||
                        r_state == sfr_pkg::S_NUM_WAIT ||
                        r_state == sfr_pkg::S_DEN_WAIT))
        else $error("divider result arrived unexpected");
`endif

endmodule

// File: verif/signed_fraction_reducer_test.sv
`timescale 1ns / 100ps
// self-checking bench for signed_fraction_reducer: a start/busy driver, a strobe monitor
// and a gcd-based predictor of the reduced fraction; depends on sfr_pkg and the block's rtl

module signed_fraction_reducer_test;

    localparam int WIDTH = sfr_pkg::DEFAULT_WIDTH;
    localparam logic [sfr_pkg::MAG_W-1:0] MAG_MASK =
        {sfr_pkg::MAG_W{1'b1}} >> (sfr_pkg::MAG_W - WIDTH);
    localparam int RANDOM_WORDS = 1800;
    localparam int PHASE_WORDS = 300;
    localparam int DRAIN_CYCLES = 7000;   // above the worst euclid latency
    localparam int STALL_LIMIT = 20000;   // cycles with no word moving either way
    localparam int REPORT_MAX = 10;
    localparam logic [sfr_pkg::MAG_W-1:0] MAG_MAX = {sfr_pkg::MAG_W{1'b1}};

    typedef struct packed {
        logic [sfr_pkg::MAG_W-1:0] num;
        logic                      num_neg;
        logic [sfr_pkg::MAG_W-1:0] den;
        logic                      den_neg;
    } t_fraction;

    typedef struct packed {
        logic [sfr_pkg::MAG_W-1:0] num;
        logic [sfr_pkg::MAG_W-1:0] den;
        logic                      neg;
    } t_reduced;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [sfr_pkg::MAG_W-1:0] i_num_magnitude = '0;
    logic                      i_num_negative = 1'b0;
    logic [sfr_pkg::MAG_W-1:0] i_den_magnitude = '0;
    logic                      i_den_negative = 1'b0;
    logic                      o_valid;
    logic [sfr_pkg::MAG_W-1:0] o_reduced_num;
    logic [sfr_pkg::MAG_W-1:0] o_reduced_den;
    logic                      o_result_negative;

    t_fraction pending_fractions[$];
    t_reduced  expected_reductions[$];
    int        words_issued = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        idle_table[3] = '{0, 79, 11};

    signed_fraction_reducer #(
        .WIDTH(WIDTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_num_magnitude  (i_num_magnitude),
        .i_num_negative   (i_num_negative),
        .i_den_magnitude  (i_den_magnitude),
        .i_den_negative   (i_den_negative),
        .o_valid          (o_valid),
        .o_reduced_num    (o_reduced_num),
        .o_reduced_den    (o_reduced_den),
        .o_result_negative(o_result_negative)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_reduced reduce_fraction(t_fraction f);
        logic [sfr_pkg::MAG_W-1:0] x;
        logic [sfr_pkg::MAG_W-1:0] y;
        logic [sfr_pkg::MAG_W-1:0] r;
        t_reduced res;
        x = f.num & MAG_MASK;
        y = f.den & MAG_MASK;
        res.num = x;
        res.den = y;
        while (y != '0) begin
            r = x % y;
            x = y;
            y = r;
        end
        // x now holds the gcd; 0 and 1 leave the magnitudes alone
        if (x > 64'd1) begin
            res.num = res.num / x;
            res.den = res.den / x;
        end
        res.neg = f.num_neg ^ f.den_neg;
        return res;
    endfunction

    function automatic logic [sfr_pkg::MAG_W-1:0] rand_bits(int n);
        logic [sfr_pkg::MAG_W-1:0] v;
        v = {$urandom, $urandom};
        if (n < sfr_pkg::MAG_W)
            v = v & ((64'd1 << n) - 64'd1);
        return v;
    endfunction

    task automatic add_fraction(logic [sfr_pkg::MAG_W-1:0] num, logic num_neg,
                                logic [sfr_pkg::MAG_W-1:0] den, logic den_neg);
        t_fraction f;
        f.num = num;
        f.num_neg = num_neg;
        f.den = den;
        f.den_neg = den_neg;
        pending_fractions.push_back(f);
    endtask

    // mostly short magnitudes keep the euclid loop short; a share spans up to 64 bits
    task automatic add_random_fraction();
        int                        cls;
        int                        bits;
        int                        half;
        logic [sfr_pkg::MAG_W-1:0] g;
        logic [sfr_pkg::MAG_W-1:0] num;
        logic [sfr_pkg::MAG_W-1:0] den;
        cls = $urandom_range(99);
        if (cls < 60)
            bits = $urandom_range(10, 1);
        else if (cls < 85)
            bits = $urandom_range(24, 11);
        else
            bits = $urandom_range(64, 25);
        half = bits / 2 + 1;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                num = rand_bits(bits);
                den = rand_bits(bits);
            end
            5, 6, 7: begin
                // shared factor so the division path is taken
                g = rand_bits(half) | 64'd2;
                num = rand_bits(half) * g;
                den = rand_bits(half) * g;
            end
            8: begin
                num = rand_bits(bits);
                den = '0;
                if ($urandom_range(1)) begin
                    den = num;
                    num = '0;
                end
            end
            default: begin
                num = rand_bits(bits);
                den = $urandom_range(1) ? num : 64'd1;
                if ($urandom_range(1)) begin
                    g = num;
                    num = den;
                    den = g;
                end
            end
        endcase
        add_fraction(num, 1'($urandom_range(1)), den, 1'($urandom_range(1)));
    endtask

    task automatic note_mismatch(string what, t_reduced exp, t_reduced got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t %s: expected %0d/%0d neg %0b, got %0d/%0d neg %0b", $realtime,
                     what, exp.num, exp.den, exp.neg, got.num, got.den, got.neg);
    endtask

    // driver: start stays up until the word is taken, then the next one may follow
    always @(posedge i_clk) begin : drive
        t_fraction f;
        t_fraction sent;
        logic      free;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                sent.num = i_num_magnitude;
                sent.num_neg = i_num_negative;
                sent.den = i_den_magnitude;
                sent.den_neg = i_den_negative;
                expected_reductions.push_back(reduce_fraction(sent));
                words_issued++;
            end
            free = !start || !busy;
            if (free && pending_fractions.size() > 0 &&
                $urandom_range(99) >= idle_table[(words_issued / PHASE_WORDS) % 3]) begin
                f = pending_fractions.pop_front();
                i_num_magnitude <= f.num;
                i_num_negative <= f.num_neg;
                i_den_magnitude <= f.den;
                i_den_negative <= f.den_neg;
                start <= 1'b1;
            end else if (free) begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_reduced got;
        t_reduced exp;
        if (i_rst_n && o_valid) begin
            got.num = o_reduced_num;
            got.den = o_reduced_den;
            got.neg = o_result_negative;
            if (expected_reductions.size() == 0) begin
                exp = '0;
                note_mismatch("result word with nothing pending", exp, got);
            end else begin
                exp = expected_reductions.pop_front();
                if (got.num !== exp.num)
                    note_mismatch("numerator mismatch", exp, got);
                else if (got.den !== exp.den)
                    note_mismatch("denominator mismatch", exp, got);
                else if (got.neg !== exp.neg)
                    note_mismatch("sign mismatch", exp, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || (i_rst_n && o_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        // zero cases, each sign pair of 0/0, then small reductions
        add_fraction(64'd0, 1'b0, 64'd0, 1'b0);
        add_fraction(64'd0, 1'b1, 64'd0, 1'b0);
        add_fraction(64'd0, 1'b0, 64'd0, 1'b1);
        add_fraction(64'd0, 1'b1, 64'd0, 1'b1);
        add_fraction(64'd0, 1'b1, 64'd1, 1'b0);
        add_fraction(64'd0, 1'b0, 64'd6, 1'b0);
        add_fraction(64'd1, 1'b0, 64'd0, 1'b0);
        add_fraction(64'd9, 1'b0, 64'd0, 1'b1);
        add_fraction(MAG_MAX, 1'b1, 64'd0, 1'b0);
        add_fraction(64'd0, 1'b1, MAG_MAX, 1'b1);
        add_fraction(64'd1, 1'b0, 64'd1, 1'b1);
        add_fraction(64'd12, 1'b0, 64'd18, 1'b0);
        add_fraction(64'd6, 1'b1, 64'd4, 1'b1);
        // field extremes
        add_fraction(MAG_MAX, 1'b0, MAG_MAX, 1'b0);
        add_fraction(MAG_MAX, 1'b1, 64'd1, 1'b0);
        add_fraction(64'd1, 1'b0, MAG_MAX, 1'b1);
        add_fraction(MAG_MAX, 1'b0, MAG_MAX - 64'd1, 1'b0);
        add_fraction(64'h8000_0000_0000_0000, 1'b0, 64'h4000_0000_0000_0000, 1'b1);
        add_fraction(64'h8000_0000_0000_0000, 1'b1, 64'h6000_0000_0000_0000, 1'b0);
        add_fraction(64'h5555_5555_5555_5555, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        // consecutive fibonacci numbers give the longest remainder chain
        add_fraction(64'd12200160415121876738, 1'b0, 64'd7540113804746346429, 1'b1);
        add_fraction(64'd7540113804746346429, 1'b1, 64'd12200160415121876738, 1'b0);
        repeat (RANDOM_WORDS) add_random_fraction();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_fractions.size() != 0 || start || expected_reductions.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_reductions.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
